/* hdl/rms_pkg.sv */
`default_nettype none
package rms_pkg;

    localparam int DATA_W      = 32;
    localparam int POS_W       = 10;
    localparam int LEAF_COUNT  = 1024;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 32;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // controls for the shared min/accumulate unit
    typedef struct packed {
        logic                     load;
        logic                     fold;
        logic signed [DATA_W-1:0] load_val;
    } t_acc_ctl;

endpackage
`default_nettype wire

/* hdl/range_min_segment_tree.sv */
`default_nettype none
// Range-minimum segment tree, bottom-up, one node RAM and one shared compare unit.
// Update: one RAM read and write per level, climbing from the written leaf to the root.
// Query: two node reads per level on one read port; the result waits for a free output.
// One transaction at a time; s_axis_tready is high only while the sequencer is idle.
// Reset (i_rst_n low, synchronous) starts a clearing pass that writes 2147483647
// to every node; no input is taken until it ends.
module range_min_segment_tree #(
    parameter int LEAF_COUNT = rms_pkg::LEAF_COUNT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [9:0] position, [19:10] range_end, [51:20] new_value, [55:52] zero
    input  wire logic [rms_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [31:0] minimum
    output logic      [rms_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rms_pkg::*;

    localparam int NODE_COUNT = 2 * LEAF_COUNT;
    localparam int AW = $clog2(NODE_COUNT);
    // wide enough for a full input position and for one past the last node
    localparam int IW = ((AW > POS_W) ? AW : POS_W) + 1;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_URD  = 3'd2;
    localparam logic [2:0] ST_UWR  = 3'd3;
    localparam logic [2:0] ST_QLO  = 3'd4;
    localparam logic [2:0] ST_QHI  = 3'd5;

    localparam logic [IW-1:0] LEAVES    = IW'(LEAF_COUNT);
    localparam logic [AW-1:0] LAST_NODE = AW'(NODE_COUNT - 1);
    localparam logic [AW-1:0] ROOT      = AW'(1);

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_k, n_k;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic          r_pend, n_pend;
    logic          r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;

    logic [POS_W-1:0]         in_pos;
    logic [POS_W-1:0]         in_end;
    logic signed [DATA_W-1:0] in_val;
    logic [IW-1:0]            pos_ext, end_ext, last_clamp, lo_tmp, hi_tmp;
    logic                     q_empty, accept, out_free;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    t_acc_ctl                 acc_ctl;
    logic signed [DATA_W-1:0] min_res;

    assign in_pos = s_axis_tdata[POS_W-1:0];
    assign in_end = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_val = $signed(s_axis_tdata[2*POS_W+DATA_W-1:2*POS_W]);

    assign pos_ext    = IW'(in_pos);
    assign end_ext    = IW'(in_end);
    assign last_clamp = (end_ext >= LEAVES) ? (LEAVES - IW'(1)) : end_ext;
    assign q_empty    = (pos_ext >= LEAVES) || (pos_ext > last_clamp);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_k         = r_k;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_clr;
        ram_wdata   = INT_MAX;
        ram_raddr   = r_k ^ ROOT;
        acc_ctl     = '{load: 1'b0, fold: 1'b0, load_val: INT_MAX};
        lo_tmp      = r_lo;
        hi_tmp      = r_hi;

        case (r_state)
            ST_CLR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + AW'(1);
                if (r_clr == LAST_NODE) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    acc_ctl.load = 1'b1;
                    if (s_axis_tuser == OP_UPDATE) begin
                        if (pos_ext < LEAVES) begin
                            ram_we           = 1'b1;
                            ram_waddr        = AW'(pos_ext + LEAVES);
                            ram_wdata        = in_val;
                            acc_ctl.load_val = in_val;
                            n_k              = AW'(pos_ext + LEAVES);
                            n_state          = ST_URD;
                        end
                    end else begin
                        if (q_empty) begin
                            n_lo = '0;
                            n_hi = '0;
                        end else begin
                            n_lo = pos_ext + LEAVES;
                            n_hi = last_clamp + IW'(1) + LEAVES;
                        end
                        n_state = ST_QLO;
                    end
                end
            end
            ST_URD: begin
                // sibling read issued here; root reached ends the climb
                if (r_k == ROOT) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_UWR;
                end
            end
            ST_UWR: begin
                acc_ctl.fold = 1'b1;
                ram_we       = 1'b1;
                ram_waddr    = r_k >> 1;
                ram_wdata    = min_res;
                n_k          = r_k >> 1;
                n_state      = ST_URD;
            end
            ST_QLO: begin
                acc_ctl.fold = r_pend;
                if (r_lo >= r_hi) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = min_res;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    if (r_lo[0]) begin
                        ram_raddr = r_lo[AW-1:0];
                        n_pend    = 1'b1;
                        n_lo      = r_lo + IW'(1);
                    end
                    n_state = ST_QHI;
                end
            end
            ST_QHI: begin
                acc_ctl.fold = r_pend;
                if (r_hi[0]) begin
                    hi_tmp    = r_hi - IW'(1);
                    ram_raddr = hi_tmp[AW-1:0];
                    n_pend    = 1'b1;
                end
                n_lo    = lo_tmp >> 1;
                n_hi    = hi_tmp >> 1;
                n_state = ST_QLO;
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_k        <= n_k;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_out_data <= n_out_data;
    end

    rms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rms_min_unit u_min (
        .i_clk     (i_clk),
        .i_ctl     (acc_ctl),
        .i_rd_data ($signed(ram_rdata)),
        .o_min     (min_res)
    );

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == ST_CLR))
        else $error("clearing pass did not start after reset");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_QLO))
        else $error("result raised outside query finish");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLR || r_state == ST_IDLE || r_state == ST_UWR))
        else $error("node write in a read-only state");

    a_pend_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_QLO || r_state == ST_QHI))
        else $error("pending node read outside query walk");

endmodule
`default_nettype wire

/* hdl/rms_ram.sv */
`default_nettype none
module rms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hdl/rms_min_unit.sv */
`default_nettype none
module rms_min_unit (
    input  wire logic                                    i_clk,
    input  wire rms_pkg::t_acc_ctl                       i_ctl,
    input  wire logic signed [rms_pkg::DATA_W-1:0]       i_rd_data,
    output logic signed      [rms_pkg::DATA_W-1:0]       o_min
);
    import rms_pkg::*;

    logic signed [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] n_acc;

    // one signed compare, shared by the update climb and the query walk
    always_comb begin
        if (i_ctl.fold && (i_rd_data < r_acc)) begin
            o_min = i_rd_data;
        end else begin
            o_min = r_acc;
        end
        n_acc = i_ctl.load ? i_ctl.load_val : o_min;
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule
`default_nettype wire
